// ===== hdl/sfq_pkg.sv =====
package sfq_pkg;

    localparam int ADDR_W  = 64;
    localparam int DATA_W  = 64;
    localparam int SIZE_W  = 2;
    localparam int AGE_W   = 16;
    localparam int SLOT_W  = 5;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_BYTE     = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_WORD     = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_LONGWORD = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_QUADWORD = 2'd3;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size_code;
        logic [DATA_W-1:0] store_value;
        logic [AGE_W-1:0]  age;
        logic              active;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] load_data;
        logic [SLOT_W-1:0] match_slot;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [SIZE_W-1:0] size;
        logic [AGE_W-1:0]  age;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic start;     // transaction accepted: latch lookup fields, clear best match
        logic write;     // accepted transaction is a store write or free
        logic scan;      // read the entry at the scan index and advance
        logic load_rsp;  // capture the result into the output register
    } sfq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_lookup;
        logic scan_last;
    } sfq_sts_t;

    function automatic logic [DATA_W-1:0] width_mask(input logic [SIZE_W-1:0] code);
        logic [DATA_W-1:0] m;
        unique case (code)
            SIZE_BYTE:     m = 64'h0000_0000_0000_00FF;
            SIZE_WORD:     m = 64'h0000_0000_0000_FFFF;
            SIZE_LONGWORD: m = 64'h0000_0000_FFFF_FFFF;
            SIZE_QUADWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:       m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/sfq_ram.sv =====
module sfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sfq_ctrl.sv =====
module sfq_ctrl import sfq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  sfq_sts_t sts,
    output sfq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FLUSH  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       accept;
    logic       out_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    cmd.write  = !sts.req_lookup;
                    state_next = sts.req_lookup ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== hdl/sfq_dp.sv =====
module sfq_dp import sfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  sfq_cmd_t cmd,
    output sfq_sts_t sts,
    output rsp_t     rsp
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W = $bits(entry_t);

    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [QUEUE_DEPTH-1:0] valid_next;
    logic                   chk_reg;
    logic                   found_reg;
    logic                   found_next;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic [ADDR_W-1:0] ld_addr_reg;
    logic [SIZE_W-1:0] ld_size_reg;
    logic [AGE_W-1:0]  ld_age_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [AGE_W-1:0]  best_age_reg;
    logic [DATA_W-1:0] best_data_reg;
    rsp_t              rsp_reg;

    logic             slot_ok;
    logic [IDX_W-1:0] widx;
    logic             ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           wentry;
    entry_t           rentry;
    logic             take;

    assign slot_ok = (32'(req.slot) < QUEUE_DEPTH);
    assign widx    = IDX_W'(req.slot);
    assign ram_we  = cmd.write && slot_ok && req.active;

    always_comb
    begin
        wentry.address = req.address;
        wentry.data    = req.store_value;
        wentry.size    = req.size_code;
        wentry.age     = req.age;
    end

    assign ram_wdata = wentry;
    assign rentry    = entry_t'(ram_rdata);

    sfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign take = chk_reg
               && valid_reg[chk_idx_reg]
               && (rentry.address == ld_addr_reg)
               && (rentry.size >= ld_size_reg)
               && (rentry.age < ld_age_reg)
               && (!found_reg || (rentry.age > best_age_reg));

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.write && slot_ok)
        begin
            valid_next[widx] = req.active;
        end
    end

    always_comb
    begin
        found_next = found_reg;
        if (cmd.start)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.scan)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            chk_reg   <= 1'b0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            chk_reg   <= cmd.scan;
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= idx_reg;
        if (cmd.start)
        begin
            ld_addr_reg <= req.address;
            ld_size_reg <= req.size_code;
            ld_age_reg  <= req.age;
        end
        if (take)
        begin
            best_idx_reg  <= chk_idx_reg;
            best_age_reg  <= rentry.age;
            best_data_reg <= rentry.data;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.hit <= found_reg;
            if (found_reg)
            begin
                rsp_reg.load_data  <= best_data_reg & width_mask(ld_size_reg);
                rsp_reg.match_slot <= SLOT_W'({{SLOT_W{1'b0}}, best_idx_reg});
            end
            else
            begin
                rsp_reg.load_data  <= '0;
                rsp_reg.match_slot <= '0;
            end
        end
    end

    assign sts.req_lookup = (req.op == OP_LOOKUP);
    assign sts.scan_last  = (idx_reg == IDX_W'(QUEUE_DEPTH - 1));
    assign rsp            = rsp_reg;

endmodule

// ===== hdl/store_to_load_forward_queue.sv =====
// Store queue with load forwarding. A write transaction (op = 0) fills a slot
// with a store's address, size, data and age, or frees it (active = 0); writes
// to slots at or above QUEUE_DEPTH are dropped. A lookup transaction (op = 1)
// returns the youngest valid store that is strictly older than the load, has
// the same address and is at least as wide, with its data masked to the load
// width and its slot number; lowest slot wins on equal ages. Every transaction
// yields exactly one result. Entries live in a single-port-read RAM that is
// walked one slot per cycle, so a lookup occupies the block for a scan of all
// slots while a write skips it. The result sits in an output register, so the
// block takes its next transaction while an earlier result is still stalled.
module store_to_load_forward_queue import sfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    sfq_cmd_t cmd;
    sfq_sts_t sts;

    sfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sfq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
